@@ hdl/aspc_pkg.sv @@
// Package: shared types, constants and codes for the axis slew profile controller.
package aspc_pkg;

    localparam int unsigned TicksPerSecDefault   = 100;
    localparam int unsigned HomeRefineTicksDefault = 3000;
    localparam int unsigned RateWidthDefault     = 32;

    localparam int CfgIdxWidth  = 3;
    localparam int CfgDataWidth = 32;

    // Register indexes
    localparam logic [CfgIdxWidth-1:0] REG_ACCEL_STEP  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_ABORT_STEP  = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_FLOOR_RATE  = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_TARGET_TOL  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_MAX_RATE    = 3'd4;
    localparam logic [CfgIdxWidth-1:0] REG_MIN_POS     = 3'd5;
    localparam logic [CfgIdxWidth-1:0] REG_MAX_POS     = 3'd6;
    localparam logic [CfgIdxWidth-1:0] REG_AXIS_EN     = 3'd7;

    // Opcodes
    localparam logic [2:0] OP_TICK  = 3'd0;
    localparam logic [2:0] OP_GOTO  = 3'd1;
    localparam logic [2:0] OP_FWD   = 3'd2;
    localparam logic [2:0] OP_REV   = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;
    localparam logic [2:0] OP_ABORT = 3'd5;
    localparam logic [2:0] OP_HOME  = 3'd6;

    // Motion modes
    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_END   = 3'd1;
    localparam logic [2:0] M_ABORT = 3'd2;
    localparam logic [2:0] M_FWD   = 3'd3;
    localparam logic [2:0] M_REV   = 3'd4;
    localparam logic [2:0] M_GOTO  = 3'd5;

    // Home stages
    localparam logic [1:0] H_NONE = 2'd0;
    localparam logic [1:0] H_FAST = 2'd1;
    localparam logic [1:0] H_SLOW = 2'd2;
    localparam logic [1:0] H_FINE = 2'd3;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STANDBY = 3'd1;
    localparam logic [2:0] ST_IN_SLEW = 3'd2;
    localparam logic [2:0] ST_LIMITS  = 3'd3;
    localparam logic [2:0] ST_FAULT   = 3'd4;

    localparam logic signed [33:0] PosFwdLimit = 34'sd1932735232;
    localparam logic signed [33:0] PosRevLimit = -34'sd1932735232;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [30:0]        new_slew_rate;
        logic [31:0]        home_timeout;
        logic               home_sense;
        logic               min_sense;
        logic               max_sense;
        logic signed [31:0] position;
        logic signed [31:0] target_distance;
        logic [30:0]        origin_distance;
        logic               in_backlash;
        logic               motor_fault;
        logic               motor_enabled;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] rate_command;
        logic [2:0]         motion_mode;
        logic [1:0]         home_stage;
        logic [2:0]         status;
        logic               slewing;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;   // capture input item and 2*accel*tps
        logic sqrt_start;  // start root
        logic mul_step;    // radicand product step
        logic div_start;   // start slew/6
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } t_dp_sts;

endpackage

@@ hdl/aspc_sqrt.sv @@
// Iterative 64-bit integer square root, one result bit per cycle.
module aspc_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_rem;
    logic [31:0] r_root;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_val;

    logic [33:0] w_trial;
    logic [33:0] w_remsh;

    // remainder shifted by next two radicand bits versus 4*root+1
    assign w_remsh = {r_rem[31:0], r_val[63:62]};
    assign w_trial = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_root <= '0;
                r_val  <= i_rad;
            end else if (r_busy) begin
                r_val <= {r_val[61:0], 2'b00};
                if (w_remsh >= w_trial) begin
                    r_rem  <= {30'd0, w_remsh - w_trial};
                    r_root <= {r_root[30:0], 1'b1};
                end else begin
                    r_rem  <= {30'd0, w_remsh};
                    r_root <= {r_root[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

@@ hdl/aspc_datapath.sv @@
// Datapath: item capture, goto radicand and root, slew divide by six.
module aspc_datapath #(
    parameter int unsigned TICKS_PER_SEC = aspc_pkg::TicksPerSecDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  aspc_pkg::t_dp_cmd   i_cmd,
    input  aspc_pkg::t_in_item  i_item,
    input  logic [23:0]         i_accel_step,
    input  logic [31:0]         i_slew,
    output aspc_pkg::t_dp_sts   o_sts,
    output aspc_pkg::t_in_item  o_item,
    output logic [31:0]         o_root,
    output logic [31:0]         o_slew_div6
);
    import aspc_pkg::*;

    localparam logic [14:0] Tps2 = 15'(2 * TICKS_PER_SEC);
    // ceil(2^34/6): floor(x/6) = (x*Recip6) >> 34 for any 32-bit x
    localparam logic [63:0] Recip6 = 64'h0000_0000_AAAA_AAAB;

    t_in_item    r_item;
    logic [38:0] r_x;       // 2*accel*tps
    logic [63:0] r_rad;
    logic [31:0] r_q;
    logic        r_ddone;
    logic        w_sqrt_done;
    logic [69:0] w_prod;
    logic [63:0] w_recip;

    // radicand: x*origin*256, saturating at 2^64-1
    assign w_prod = {31'd0, r_x} * {39'd0, r_item.origin_distance};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_item;
            r_x    <= {15'd0, i_accel_step} * {24'd0, Tps2};
        end
        if (i_cmd.mul_step) begin
            r_rad <= (|w_prod[69:56]) ? '1 : {w_prod[55:0], 8'd0};
        end
    end

    aspc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.sqrt_start),
        .i_rad  (r_rad),
        .o_done (w_sqrt_done),
        .o_root (o_root)
    );

    // division by six through a reciprocal product, quotient registered
    assign w_recip = {32'd0, i_slew} * Recip6;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= i_cmd.div_start;
            if (i_cmd.div_start) r_q <= {2'd0, w_recip[63:34]};
        end
    end

    assign o_sts       = '{sqrt_done: w_sqrt_done, div_done: r_ddone};
    assign o_item      = r_item;
    assign o_slew_div6 = r_q;
endmodule

@@ hdl/aspc_ctrl.sv @@
// Controller: handshake sequencing and motion state update.
module aspc_ctrl #(
    parameter int unsigned HOME_REFINE_TICKS = aspc_pkg::HomeRefineTicksDefault,
    parameter int unsigned RATE_WIDTH        = aspc_pkg::RateWidthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output aspc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [aspc_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [aspc_pkg::CfgDataWidth-1:0] i_cfg_data,
    output aspc_pkg::t_dp_cmd   o_cmd,
    input  aspc_pkg::t_dp_sts   i_sts,
    input  aspc_pkg::t_in_item  i_item,
    input  logic [31:0]         i_root,
    input  logic [31:0]         i_slew_div6,
    output logic [23:0]         o_accel_step,
    output logic [31:0]         o_slew
);
    import aspc_pkg::*;

    localparam logic signed [33:0] RateMax =
        34'sd2 ** (RATE_WIDTH > 33 ? 33 : RATE_WIDTH - 1) - 34'sd1;
    localparam logic [31:0] HomeTicks = 32'(HOME_REFINE_TICKS);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_START, S_ROOT, S_EXEC, S_DIV, S_OUT
    } t_state;

    t_state      r_state;
    t_out_item   r_out;
    logic        r_out_valid;
    logic [23:0] r_accel, r_abort, r_floor;
    logic [15:0] r_tol;
    logic [30:0] r_max_rate;
    logic signed [31:0] r_min_pos, r_max_pos;
    logic        r_axis_en;
    logic [2:0]  r_mode;
    logic [1:0]  r_hstage;
    logic signed [33:0] r_rate;
    logic [31:0] r_slew;
    logic [31:0] r_timer;

    logic [2:0]  n_mode;
    logic [1:0]  n_hstage;
    logic signed [33:0] n_rate;
    logic [31:0] n_slew, n_timer;
    logic [2:0]  n_status;
    logic        n_need_div;

    assign o_accel_step = r_accel;
    assign o_slew       = r_slew;

    // motion error check
    function automatic logic mot_err(input logic fwd, input logic rev,
            input logic [1:0] hs, input t_in_item it,
            input logic signed [31:0] mn, input logic signed [31:0] mx);
        logic signed [33:0] p;
        logic e;
        p = 34'(it.position);
        e = 1'b0;
        if (fwd) e = e || p > PosFwdLimit || (hs == H_NONE && p > 34'(mx) + 34'sd1)
                     || it.max_sense;
        if (rev) e = e || p < PosRevLimit || (hs == H_NONE && p < 34'(mn) - 34'sd1)
                     || it.min_sense;
        return e;
    endfunction

    function automatic logic signed [33:0] clamp_slew(input logic signed [33:0] f,
            input logic [30:0] mr);
        logic signed [33:0] g;
        g = f;
        if (mr != '0 && g > $signed({3'd0, mr})) g = $signed({3'd0, mr});
        if (g > RateMax) g = RateMax;
        return g;
    endfunction

    // item evaluation (once the root is ready); also the end-ramp homing restart
    always_comb begin
        logic signed [33:0] st, ab, sl, gr, tl, f;
        logic [2:0]  m;
        logic [1:0]  hs;
        logic        tick_en, err, fwd, rev, done, home_go;
        logic [31:0] tmo;
        m = r_mode; hs = r_hstage; n_rate = r_rate; n_slew = r_slew;
        n_timer = r_timer; n_status = ST_OK; n_need_div = 1'b0;
        st = $signed({10'd0, r_accel}); ab = $signed({10'd0, r_abort});
        sl = $signed({2'd0, r_slew}); tl = $signed({18'd0, r_tol});
        tick_en = 1'b0; home_go = 1'b0; tmo = i_item.home_timeout;
        gr = '0; f = '0; err = 1'b0; fwd = 1'b0; rev = 1'b0; done = 1'b0;
        case (i_item.opcode)
            OP_TICK: tick_en = 1'b1;
            OP_GOTO: begin
                if (!r_axis_en) n_status = ST_STANDBY;
                else if (m != M_IDLE) n_status = ST_IN_SLEW;
                else if (mot_err(1'b1, 1'b1, hs, i_item, r_min_pos, r_max_pos))
                    n_status = ST_LIMITS;
                else if (i_item.motor_fault) n_status = ST_FAULT;
                else begin
                    if (i_item.new_slew_rate != '0)
                        n_slew = 32'(clamp_slew($signed({3'd0, i_item.new_slew_rate}),
                                                r_max_rate));
                    m = M_GOTO;
                end
            end
            OP_FWD, OP_REV: begin
                fwd = (i_item.opcode == OP_FWD);
                if (!r_axis_en) n_status = ST_STANDBY;
                else if (m == M_GOTO) n_status = ST_IN_SLEW;
                else if (mot_err(fwd, !fwd, hs, i_item, r_min_pos, r_max_pos))
                    n_status = ST_LIMITS;
                else if (i_item.motor_fault) n_status = ST_FAULT;
                else begin
                    if (i_item.new_slew_rate != '0)
                        n_slew = 32'(clamp_slew($signed({3'd0, i_item.new_slew_rate}),
                                                r_max_rate));
                    m = fwd ? M_FWD : M_REV;
                end
            end
            OP_STOP: if (m > M_END) begin
                m = M_END; tick_en = 1'b1;
            end
            OP_ABORT: if (m > M_ABORT) begin
                m = M_ABORT; hs = H_NONE; tick_en = 1'b1;
            end
            OP_HOME: home_go = 1'b1;
            default: ;
        endcase
        if (tick_en) begin
            sl = $signed({2'd0, n_slew});
            if (hs != H_NONE && (m == M_FWD || m == M_REV)) begin
                if ((m == M_FWD && !i_item.home_sense) || (m == M_REV && i_item.home_sense))
                    m = M_END;
                if (n_timer == '0) begin
                    if (m > M_ABORT) begin
                        m = M_ABORT; hs = H_NONE;
                    end
                end else n_timer = n_timer - 32'd1;
            end
            if (m != M_IDLE && !i_item.in_backlash) begin
                if (m != M_ABORT) begin
                    fwd = n_rate > 0; rev = n_rate < 0;
                    err = mot_err(fwd, rev, hs, i_item, r_min_pos, r_max_pos);
                    if (err || i_item.motor_fault) begin
                        m = M_ABORT; hs = H_NONE;
                    end
                end
                case (m)
                    M_GOTO: begin
                        if (34'(i_item.target_distance) <= tl
                            && 34'(i_item.target_distance) >= -tl) begin
                            m = M_IDLE; n_rate = '0;
                        end else begin
                            gr = $signed({2'd0, i_root});
                            if (gr < $signed({10'd0, r_floor})) gr = $signed({10'd0, r_floor});
                            if (gr > sl) gr = sl;
                            n_rate = i_item.target_distance[31] ? -gr : gr;
                        end
                    end
                    M_FWD: begin
                        n_rate = n_rate + st;
                        if (n_rate > sl) n_rate = sl;
                    end
                    M_REV: begin
                        n_rate = n_rate - st;
                        if (n_rate < -sl) n_rate = -sl;
                    end
                    M_END, M_ABORT: begin
                        f = (m == M_END) ? st : ab;
                        if (n_rate > f) n_rate = n_rate - f;
                        else if (n_rate < -f) n_rate = n_rate + f;
                        else n_rate = '0;
                        done = n_rate <= f && n_rate >= -f;
                        if (done) begin
                            n_rate = '0;
                            if (m == M_ABORT) m = M_IDLE;
                            else begin
                                m = M_IDLE;
                                // homing stage advance; slew update in S_DIV
                                if (hs == H_FAST) begin
                                    hs = H_SLOW; n_need_div = 1'b1;
                                end else if (hs == H_SLOW) begin
                                    if (!i_item.home_sense) begin
                                        hs = H_FINE; n_need_div = 1'b1;
                                    end else home_go = 1'b1;
                                end else if (hs == H_FINE) hs = H_NONE;
                                if (hs != H_NONE && !home_go) home_go = 1'b1;
                                if (n_need_div) home_go = 1'b0;
                                tmo = HomeTicks;
                                if (home_go) begin
                                    f = clamp_slew((sl < 1) ? 34'sd1 : sl, r_max_rate);
                                    n_slew = 32'(f);
                                end
                            end
                        end
                    end
                    default: n_rate = '0;
                endcase
            end else n_rate = '0;
            if (n_rate > RateMax) n_rate = RateMax;
            if (n_rate < -RateMax) n_rate = -RateMax;
        end
        // home start
        if (home_go) begin
            if (!r_axis_en) n_status = (i_item.opcode == OP_HOME) ? ST_STANDBY : ST_OK;
            else if (m != M_IDLE) n_status = (i_item.opcode == OP_HOME) ? ST_IN_SLEW : ST_OK;
            else if (mot_err(1'b1, 1'b1, hs, i_item, r_min_pos, r_max_pos))
                n_status = (i_item.opcode == OP_HOME) ? ST_LIMITS : ST_OK;
            else if (i_item.motor_fault)
                n_status = (i_item.opcode == OP_HOME) ? ST_FAULT : ST_OK;
            else begin
                if (hs == H_NONE) hs = H_FAST;
                m = i_item.home_sense ? M_FWD : M_REV;
                n_timer = (tmo != '0) ? tmo : HomeTicks;
            end
        end
        if (tick_en && !n_need_div && m != M_IDLE && !i_item.motor_enabled) begin
            m = M_IDLE; n_rate = '0;
        end
        n_mode = m; n_hstage = hs;
    end

    // restart after divide: slew/6 (at least 1, clamped), then home start
    logic [2:0]  d_mode;
    logic [1:0]  d_hstage;
    logic [31:0] d_slew, d_timer;
    always_comb begin
        logic signed [33:0] f;
        f = $signed({2'd0, i_slew_div6});
        if (f < 1) f = 34'sd1;
        d_slew = 32'(clamp_slew(f, r_max_rate));
        d_mode = r_mode; d_hstage = r_hstage; d_timer = r_timer;
        if (r_axis_en && !mot_err(1'b1, 1'b1, r_hstage, i_item, r_min_pos, r_max_pos)
            && !i_item.motor_fault) begin
            d_mode = i_item.home_sense ? M_FWD : M_REV;
            d_timer = HomeTicks;
        end
        if (d_mode != M_IDLE && !i_item.motor_enabled) d_mode = M_IDLE;
    end

    // output item, clamped to max_rate when it is nonzero, zero when axis disabled
    function automatic t_out_item mk_out(input logic signed [33:0] rt,
            input logic [2:0] m, input logic [1:0] hs, input logic [2:0] s);
        t_out_item o;
        logic signed [33:0] r;
        r = rt;
        if (!r_axis_en) r = '0;
        else if (r_max_rate != '0) begin
            if (r > $signed({3'd0, r_max_rate})) r = $signed({3'd0, r_max_rate});
            if (r < -$signed({3'd0, r_max_rate})) r = -$signed({3'd0, r_max_rate});
        end
        o.rate_command = r[31:0];
        o.motion_mode  = m;
        o.home_stage   = hs;
        o.status       = s;
        o.slewing      = (m != M_IDLE);
        return o;
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // radicand is registered in S_MUL, the root starts from it in S_START
    always_comb begin
        o_cmd            = '0;
        o_cmd.load_item  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul_step   = (r_state == S_MUL);
        o_cmd.sqrt_start = (r_state == S_START);
        o_cmd.div_start  = (r_state == S_EXEC) && n_need_div;
    end

    // sequencer and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_accel     <= 24'd256;
            r_abort     <= 24'd1024;
            r_floor     <= 24'd256;
            r_tol       <= 16'd1;
            r_max_rate  <= '0;
            r_min_pos   <= 32'sh80000000;
            r_max_pos   <= 32'sh7fffffff;
            r_axis_en   <= 1'b0;
            r_mode      <= M_IDLE;
            r_hstage    <= H_NONE;
            r_rate      <= '0;
            r_slew      <= '0;
            r_timer     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACCEL_STEP: r_accel    <= i_cfg_data[23:0];
                    REG_ABORT_STEP: r_abort    <= i_cfg_data[23:0];
                    REG_FLOOR_RATE: r_floor    <= i_cfg_data[23:0];
                    REG_TARGET_TOL: r_tol      <= i_cfg_data[15:0];
                    REG_MAX_RATE:   r_max_rate <= i_cfg_data[30:0];
                    REG_MIN_POS:    r_min_pos  <= $signed(i_cfg_data);
                    REG_MAX_POS:    r_max_pos  <= $signed(i_cfg_data);
                    REG_AXIS_EN:    r_axis_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_MUL;
                S_MUL:   r_state <= S_START;
                S_START: r_state <= S_ROOT;
                S_ROOT:  if (i_sts.sqrt_done) r_state <= S_EXEC;
                S_EXEC: begin
                    r_mode   <= n_mode;
                    r_hstage <= n_hstage;
                    r_rate   <= n_rate;
                    r_slew   <= n_slew;
                    r_timer  <= n_timer;
                    if (n_need_div) r_state <= S_DIV;
                    else begin
                        r_out       <= mk_out(n_rate, n_mode, n_hstage, n_status);
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_DIV: if (i_sts.div_done) begin
                    r_slew   <= d_slew;
                    r_mode   <= d_mode;
                    r_timer  <= d_timer;
                    r_out    <= mk_out(r_rate, d_mode, d_hstage, ST_OK);
                    r_out_valid <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: if (!r_out_valid || i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_out_valid || r_state == S_IDLE)
        else $error("ready while busy");
    a_rate_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == M_IDLE) |-> (r_rate == '0))
        else $error("rate nonzero in idle");
    a_rate_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rate <= RateMax) && (r_rate >= -RateMax))
        else $error("rate out of range");
`endif
endmodule

@@ hdl/axis_slew_profile_controller.sv @@
// Top level: axis slew profile controller, controller plus datapath.
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data) carries one tick or
//   command item; output channel (o_out_valid/i_out_ready, o_out_data)
//   returns exactly one result item per input item.
//   Configuration registers are written through i_cfg_we/i_cfg_idx/
//   i_cfg_data while the block is idle.
// Sequencing:
//   One item at a time. The result is valid once the accepted item has
//   passed capture, radicand product, root start, the bit-serial square
//   root and state update. A homing stage change adds the divide-by-six
//   product before the result.
// Reset:
//   Synchronous, active low: mode idle, no homing, rate and slew zero,
//   registers at their defaults.
// Stall:
//   A stalled receiver holds the result; no new item is taken until it
//   is delivered.
module axis_slew_profile_controller #(
    parameter int unsigned TICKS_PER_SEC     = aspc_pkg::TicksPerSecDefault,
    parameter int unsigned HOME_REFINE_TICKS = aspc_pkg::HomeRefineTicksDefault,
    parameter int unsigned RATE_WIDTH        = aspc_pkg::RateWidthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aspc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output aspc_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [aspc_pkg::CfgIdxWidth-1:0]  i_cfg_idx,
    input  logic [aspc_pkg::CfgDataWidth-1:0] i_cfg_data
);
    import aspc_pkg::*;

    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;
    t_in_item    w_item;
    logic [31:0] w_root, w_div6, w_slew;
    logic [23:0] w_accel;

    aspc_datapath #(.TICKS_PER_SEC(TICKS_PER_SEC)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_in_data),
        .i_accel_step(w_accel),
        .i_slew      (w_slew),
        .o_sts       (w_sts),
        .o_item      (w_item),
        .o_root      (w_root),
        .o_slew_div6 (w_div6)
    );

    aspc_ctrl #(
        .HOME_REFINE_TICKS(HOME_REFINE_TICKS),
        .RATE_WIDTH       (RATE_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts),
        .i_item      (w_item),
        .i_root      (w_root),
        .i_slew_div6 (w_div6),
        .o_accel_step(w_accel),
        .o_slew      (w_slew)
    );
endmodule
